FILE: design/orb_pkg.sv
// ----------------------------------------------------------------------------
// orb_pkg: shared types and constants of the overwriting ring buffer
// Holds the channel payloads, command codes, controller states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package orb_pkg;

  localparam int DATA_W = 32;
  localparam int CNT_W  = 7;

  localparam logic [CNT_W-1:0] CAP_RESET = 7'd16;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_POP    = 2'd1,
    OP_CLEAN  = 2'd2,
    OP_DUMP   = 2'd3
  } orb_op_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_DATA = 1'b1
  } orb_state_t;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [DATA_W-1:0] data_in;
  } orb_in_t;

  typedef struct packed {
    logic [DATA_W-1:0] data_out;
    logic              status;
    logic [CNT_W-1:0]  count;
    logic              full_res;
    logic              last;
  } orb_out_t;

  typedef struct packed {
    logic [CNT_W-1:0] capacity;
  } orb_cfg_t;

  // controller to datapath
  typedef struct packed {
    logic append;
    logic pop;
    logic clean;
    logic start_rd;
    logic emit_word;
    logic emit_plain;
    logic emit_empty;
  } orb_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic empty;
    logic last_word;
  } orb_sts_t;

endpackage

FILE: design/orb_chan_if.sv
// ----------------------------------------------------------------------------
// orb_chan_if: valid/ready channel
// One transaction moves when valid and ready are both high at a clock edge.
// ----------------------------------------------------------------------------
interface orb_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

FILE: design/overwriting_ring_buffer.sv
// ----------------------------------------------------------------------------
// overwriting_ring_buffer: circular FIFO that overwrites its oldest word
// Append, clean and empty-buffer results: registered, one per cycle while the
// result side takes them. Pop and dump: each word passes the registered read
// port of the word memory and then the output register; dump words follow one
// per cycle while results are taken. No command is taken until the last word.
// Reset (synchronous, rst_n low) empties the buffer and sets capacity to 16;
// the word memory is not cleared.
// ----------------------------------------------------------------------------
module overwriting_ring_buffer #(
  parameter int DEPTH     = 16,
  parameter int WORD_BITS = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  orb_chan_if.sink   in_chan,
  orb_chan_if.source out_chan,
  orb_chan_if.sink   cfg_chan
);

  orb_pkg::orb_cmd_t cmd;
  orb_pkg::orb_sts_t sts;
  orb_pkg::orb_out_t res;
  logic              cfg_we;

  // configuration must only arrive while idle (not enforced here); it is always taken
  assign cfg_chan.ready = 1'b1;
  assign cfg_we         = cfg_chan.valid;

  orb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .in_op     (orb_pkg::orb_op_t'(in_chan.payload.cmd)),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  orb_dp #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
  ) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .in_data (in_chan.payload.data_in),
    .cfg_we  (cfg_we),
    .cfg_cap (cfg_chan.payload.capacity),
    .sts     (sts),
    .res     (res)
  );

  assign out_chan.payload = res;

endmodule

FILE: design/orb_ctrl.sv
// ----------------------------------------------------------------------------
// orb_ctrl: command sequencer
// Decodes accepted commands, steps pops and dumps through the read port and
// owns the output valid flag.
// ----------------------------------------------------------------------------
module orb_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  orb_pkg::orb_op_t  in_op,
  output logic              out_valid,
  input  logic              out_ready,
  input  orb_pkg::orb_sts_t sts,
  output orb_pkg::orb_cmd_t cmd
);

  orb_pkg::orb_state_t state_r, state_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                slot_free;

  assign slot_free = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= orb_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      orb_pkg::ST_IDLE: begin
        in_ready = slot_free;
        if (in_valid && slot_free) begin
          unique case (in_op)
            orb_pkg::OP_APPEND: begin
              cmd.append     = 1'b1;
              cmd.emit_plain = 1'b1;
            end
            orb_pkg::OP_CLEAN: begin
              cmd.clean      = 1'b1;
              cmd.emit_plain = 1'b1;
            end
            orb_pkg::OP_POP: begin
              if (sts.empty) begin
                cmd.emit_empty = 1'b1;
              end else begin
                cmd.pop      = 1'b1;
                cmd.start_rd = 1'b1;
                state_nxt    = orb_pkg::ST_DATA;
              end
            end
            orb_pkg::OP_DUMP: begin
              if (sts.empty) begin
                cmd.emit_empty = 1'b1;
              end else begin
                cmd.start_rd = 1'b1;
                state_nxt    = orb_pkg::ST_DATA;
              end
            end
            default: begin
              cmd = '0;
            end
          endcase
        end
      end
      orb_pkg::ST_DATA: begin
        // read data is valid here; hold it while the output slot is busy
        if (slot_free) begin
          cmd.emit_word = 1'b1;
          if (sts.last_word) begin
            state_nxt = orb_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = orb_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.emit_plain || cmd.emit_empty || cmd.emit_word) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

endmodule

FILE: design/orb_dp.sv
// ----------------------------------------------------------------------------
// orb_dp: ring buffer datapath
// Word memory, head/tail pointers, entry count, capacity register, the read
// cursor for pops and dumps, and the output register.
// ----------------------------------------------------------------------------
module orb_dp #(
  parameter int DEPTH     = 16,
  parameter int WORD_BITS = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  orb_pkg::orb_cmd_t                cmd,
  input  logic [orb_pkg::DATA_W-1:0]       in_data,
  input  logic                             cfg_we,
  input  logic [orb_pkg::CNT_W-1:0]        cfg_cap,
  output orb_pkg::orb_sts_t                sts,
  output orb_pkg::orb_out_t                res
);

  localparam int SW = (WORD_BITS < orb_pkg::DATA_W) ? WORD_BITS : orb_pkg::DATA_W;
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [orb_pkg::CNT_W-1:0] DEPTH_C = orb_pkg::CNT_W'(DEPTH);

  logic [SW-1:0]               mem [DEPTH];
  logic [SW-1:0]               rd_q;
  logic [PW-1:0]               rd_addr;

  logic [orb_pkg::CNT_W-1:0]   cap_r, cap_nxt;
  logic [orb_pkg::CNT_W-1:0]   eff_cap;
  logic [PW-1:0]               head_r, head_nxt;
  logic [PW-1:0]               tail_r, tail_nxt;
  logic [orb_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                        full_r, full_nxt;
  logic [PW-1:0]               p_r, p_nxt;
  logic [orb_pkg::CNT_W-1:0]   remain_r, remain_nxt;
  orb_pkg::orb_out_t           out_r, out_nxt;

  function automatic logic [PW-1:0] adv(input logic [PW-1:0] p,
                                        input logic [orb_pkg::CNT_W-1:0] c);
    logic [orb_pkg::CNT_W-1:0] n;
    n = orb_pkg::CNT_W'(p) + 1'b1;
    return (n >= c) ? '0 : n[PW-1:0];
  endfunction

  always_comb begin
    if (cap_r == '0) begin
      eff_cap = orb_pkg::CNT_W'(1);
    end else if (cap_r > DEPTH_C) begin
      eff_cap = DEPTH_C;
    end else begin
      eff_cap = cap_r;
    end
  end

  // buffer state
  always_comb begin
    cap_nxt  = cap_r;
    head_nxt = head_r;
    tail_nxt = tail_r;
    cnt_nxt  = cnt_r;
    full_nxt = full_r;
    priority if (cfg_we) begin
      cap_nxt  = cfg_cap;
      head_nxt = '0;
      tail_nxt = '0;
      cnt_nxt  = '0;
      full_nxt = 1'b0;
    end else if (cmd.clean) begin
      head_nxt = '0;
      tail_nxt = '0;
      cnt_nxt  = '0;
      full_nxt = 1'b0;
    end else if (cmd.append) begin
      tail_nxt = adv(tail_r, eff_cap);
      // full: overwrite the oldest entry and drag the head along
      if (cnt_r >= eff_cap) begin
        head_nxt = adv(head_r, eff_cap);
      end else begin
        cnt_nxt = cnt_r + 1'b1;
      end
      full_nxt = (cnt_nxt == eff_cap);
    end else if (cmd.pop) begin
      cnt_nxt  = cnt_r - 1'b1;
      full_nxt = 1'b0;
      if (cnt_nxt == '0) begin
        head_nxt = '0;
        tail_nxt = '0;
      end else begin
        head_nxt = adv(head_r, eff_cap);
      end
    end else begin
      cnt_nxt = cnt_r;
    end
  end

  // read cursor: prefetch the next word whenever the current one is taken
  always_comb begin
    p_nxt      = p_r;
    remain_nxt = remain_r;
    rd_addr    = p_r;
    if (cmd.start_rd) begin
      p_nxt      = head_r;
      rd_addr    = head_r;
      remain_nxt = cmd.pop ? orb_pkg::CNT_W'(1) : cnt_r;
    end else if (cmd.emit_word) begin
      p_nxt      = adv(p_r, eff_cap);
      rd_addr    = p_nxt;
      remain_nxt = remain_r - 1'b1;
    end
  end

  always_comb begin
    out_nxt          = out_r;
    out_nxt.count    = cnt_nxt;
    out_nxt.full_res = full_nxt;
    out_nxt.data_out = '0;
    out_nxt.status   = 1'b0;
    out_nxt.last     = 1'b1;
    priority if (cmd.emit_word) begin
      out_nxt.data_out = orb_pkg::DATA_W'(rd_q);
      out_nxt.last     = (remain_r == orb_pkg::CNT_W'(1));
    end else if (cmd.emit_empty) begin
      out_nxt.status = 1'b1;
    end else if (cmd.emit_plain) begin
      out_nxt.status = 1'b0;
    end else begin
      out_nxt = out_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r    <= orb_pkg::CAP_RESET;
      head_r   <= '0;
      tail_r   <= '0;
      cnt_r    <= '0;
      full_r   <= 1'b0;
      p_r      <= '0;
      remain_r <= '0;
    end else begin
      cap_r    <= cap_nxt;
      head_r   <= head_nxt;
      tail_r   <= tail_nxt;
      cnt_r    <= cnt_nxt;
      full_r   <= full_nxt;
      p_r      <= p_nxt;
      remain_r <= remain_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (cmd.append) begin
      mem[tail_r] <= in_data[SW-1:0];
    end
    rd_q <= mem[rd_addr];
  end

  assign sts.empty     = (cnt_r == '0);
  assign sts.last_word = (remain_r == orb_pkg::CNT_W'(1));
  assign res           = out_r;

endmodule

FILE: bench/ring_buffer_checker.sv
// ----------------------------------------------------------------------------
// ring_buffer_checker: result predictor and comparator for the ring buffer
// Watches the command, result and capacity channels. It keeps its own copy
// of the ring contents and pointers, queues the results that each accepted
// command must produce and compares every accepted result with the oldest
// queued one, field by field.
// ----------------------------------------------------------------------------
module ring_buffer_checker #(
  parameter int DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  orb_pkg::orb_in_t  in_item,
  input  logic              out_valid,
  input  logic              out_ready,
  input  orb_pkg::orb_out_t out_item,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  orb_pkg::orb_cfg_t cfg_item,
  output int                mismatch_count,
  output int                results_outstanding
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [orb_pkg::DATA_W-1:0] word_mem [DEPTH];
  logic [5:0]                 head_idx;
  logic [5:0]                 tail_idx;
  logic [orb_pkg::CNT_W-1:0]  stored;
  logic [orb_pkg::CNT_W-1:0]  cap_reg;
  logic                       is_full;
  orb_pkg::orb_out_t          ring_results_due [$];

  // capacity in use: zero acts as one, anything above DEPTH is clamped
  function automatic int usable_slots();
    int c;
    c = int'(cap_reg);
    if (c == 0) c = 1;
    if (c > DEPTH) c = DEPTH;
    return c;
  endfunction

  function automatic logic [5:0] step_index(logic [5:0] p);
    int n;
    n = int'(p) + 1;
    return (n >= usable_slots()) ? 6'd0 : 6'(n);
  endfunction

  function automatic void empty_ring();
    head_idx = '0;
    tail_idx = '0;
    stored   = '0;
    is_full  = 1'b0;
  endfunction

  function automatic void queue_result(logic [orb_pkg::DATA_W-1:0] word, logic empty_flag,
                                       logic final_flag);
    orb_pkg::orb_out_t r;
    r.data_out = word;
    r.status   = empty_flag;
    r.count    = stored;
    r.full_res = is_full;
    r.last     = final_flag;
    ring_results_due.push_back(r);
  endfunction

  function automatic void apply_ring_command(orb_pkg::orb_in_t item);
    int                         cap;
    int                         n;
    logic [5:0]                 p;
    logic [orb_pkg::DATA_W-1:0] w;
    cap = usable_slots();
    case (orb_pkg::orb_op_t'(item.cmd))
      orb_pkg::OP_APPEND: begin
        p = (tail_idx < DEPTH) ? tail_idx : 6'd0;
        word_mem[p[IW-1:0]] = item.data_in;
        tail_idx = step_index(p);
        // full: overwrite the oldest entry, head moves along with tail
        if (stored >= cap) head_idx = step_index(head_idx);
        else stored = stored + 1'b1;
        is_full = (stored == cap);
        queue_result('0, 1'b0, 1'b1);
      end
      orb_pkg::OP_POP: begin
        if (stored == 0) begin
          queue_result('0, 1'b1, 1'b1);
        end else begin
          p = (head_idx < DEPTH) ? head_idx : 6'd0;
          w = word_mem[p[IW-1:0]];
          stored = stored - 1'b1;
          is_full = 1'b0;
          // drained: both pointers go back to slot zero
          if (stored == 0) begin
            head_idx = '0;
            tail_idx = '0;
          end else begin
            head_idx = step_index(p);
          end
          queue_result(w, 1'b0, 1'b1);
        end
      end
      orb_pkg::OP_CLEAN: begin
        empty_ring();
        queue_result('0, 1'b0, 1'b1);
      end
      orb_pkg::OP_DUMP: begin
        if (stored == 0) begin
          queue_result('0, 1'b1, 1'b1);
        end else begin
          n = (int'(stored) > DEPTH) ? DEPTH : int'(stored);
          p = (head_idx < DEPTH) ? head_idx : 6'd0;
          for (int i = 0; i < n; i++) begin
            queue_result(word_mem[p[IW-1:0]], 1'b0, i == n - 1);
            p = step_index(p);
          end
        end
      end
    endcase
  endfunction

  function automatic void check_field(string name, logic [orb_pkg::DATA_W-1:0] want,
                                      logic [orb_pkg::DATA_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin : track
    orb_pkg::orb_out_t want;
    if (!rst_n) begin
      cap_reg = orb_pkg::CAP_RESET;
      empty_ring();
      ring_results_due.delete();
      mismatch_count = 0;
    end else begin
      // results come from earlier transactions: compare before queuing new ones
      if (out_valid && out_ready) begin
        if (ring_results_due.size() == 0) begin
          $error("data_out: expected no result, got %0h", out_item.data_out);
          mismatch_count++;
        end else begin
          want = ring_results_due.pop_front();
          check_field("data_out", want.data_out, out_item.data_out);
          check_field("status", orb_pkg::DATA_W'(want.status),
                      orb_pkg::DATA_W'(out_item.status));
          check_field("count", orb_pkg::DATA_W'(want.count),
                      orb_pkg::DATA_W'(out_item.count));
          check_field("full_res", orb_pkg::DATA_W'(want.full_res),
                      orb_pkg::DATA_W'(out_item.full_res));
          check_field("last", orb_pkg::DATA_W'(want.last),
                      orb_pkg::DATA_W'(out_item.last));
        end
      end
      if (cfg_valid && cfg_ready) begin
        cap_reg = cfg_item.capacity;
        empty_ring();
      end
      if (in_valid && in_ready) apply_ring_command(in_item);
    end
    results_outstanding <= ring_results_due.size();
  end

endmodule

FILE: bench/tb_overwriting_ring_buffer.sv
// ----------------------------------------------------------------------------
// tb_overwriting_ring_buffer: stimulus and verdict for the ring buffer
// Runs a short directed sequence at the reset capacity, then a series of
// capacity settings, each with a burst of appends past the capacity and a
// random mix of append, pop, clean and dump. Both channels idle at random;
// one phase holds the result side off for a long stretch.
// ----------------------------------------------------------------------------
module tb_overwriting_ring_buffer;

  localparam int RING_DEPTH  = 16;
  localparam int PHASE_ITEMS = 36;
  localparam int HOLD_CYCLES = 300;
  localparam int QUIET_LIMIT = 3000;
  localparam int TAIL_CYCLES = 40;
  localparam int PLAN_LEN    = 10;

  logic clk = 1'b0;
  logic rst_n;
  logic quiet_run;
  int   hold_requests;
  int   idle_run = 0;
  int   mismatch_count;
  int   results_outstanding;

  logic [orb_pkg::CNT_W-1:0] cap_plan [PLAN_LEN] =
    '{7'd1, 7'd0, 7'd127, 7'd3, 7'd16, 7'd64, 7'd17, 7'd5, 7'd2, 7'd16};

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  orb_chan_if #(.T(orb_pkg::orb_in_t))  in_if  ();
  orb_chan_if #(.T(orb_pkg::orb_out_t)) out_if ();
  orb_chan_if #(.T(orb_pkg::orb_cfg_t)) cfg_if ();

  overwriting_ring_buffer #(
    .DEPTH     (RING_DEPTH),
    .WORD_BITS (orb_pkg::DATA_W)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_chan (cfg_if)
  );

  ring_buffer_checker #(
    .DEPTH (RING_DEPTH)
  ) checker_i (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_if.valid),
    .in_ready            (in_if.ready),
    .in_item             (in_if.payload),
    .out_valid           (out_if.valid),
    .out_ready           (out_if.ready),
    .out_item            (out_if.payload),
    .cfg_valid           (cfg_if.valid),
    .cfg_ready           (cfg_if.ready),
    .cfg_item            (cfg_if.payload),
    .mismatch_count      (mismatch_count),
    .results_outstanding (results_outstanding)
  );

  // result side: random stalls, plus a long hold-off on request
  initial begin : result_side
    int hold_left;
    int holds_served;
    hold_left = 0;
    holds_served = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left == 0 && holds_served != hold_requests) begin
        holds_served = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= quiet_run || ($urandom_range(99) >= 6);
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_run <= 0;
    end else begin
      idle_run <= idle_run + 1;
    end
    if (idle_run >= QUIET_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic logic [orb_pkg::DATA_W-1:0] pick_word();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return $urandom();
    endcase
  endfunction

  // leaves valid high after the transaction; the next call or a drain resets it
  task automatic offer_command(orb_pkg::orb_op_t op, logic [orb_pkg::DATA_W-1:0] word);
    logic took;
    while (!quiet_run && $urandom_range(99) < 6) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.payload <= '{cmd: op, data_in: word};
    do begin
      @(negedge clk);
      took = in_if.ready;
      @(posedge clk);
    end while (!took);
  endtask

  task automatic wait_for_results();
    in_if.valid <= 1'b0;
    do @(negedge clk); while (results_outstanding != 0);
    @(posedge clk);
  endtask

  task automatic write_capacity(logic [orb_pkg::CNT_W-1:0] cap);
    logic took;
    cfg_if.valid   <= 1'b1;
    cfg_if.payload <= '{capacity: cap};
    do begin
      @(negedge clk);
      took = cfg_if.ready;
      @(posedge clk);
    end while (!took);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic run_phase(logic [orb_pkg::CNT_W-1:0] cap);
    int               fill;
    int               half;
    int               r;
    orb_pkg::orb_op_t op;
    fill = (cap == 0) ? 1 : ((cap > RING_DEPTH) ? RING_DEPTH : int'(cap));
    // overrun the capacity so the oldest words get overwritten, then dump the ring
    for (int i = 0; i < fill + 2; i++) offer_command(orb_pkg::OP_APPEND, pick_word());
    offer_command(orb_pkg::OP_DUMP, pick_word());
    half = (fill + 3 + PHASE_ITEMS) / 2;
    for (int i = fill + 3; i < PHASE_ITEMS; i++) begin
      if (i == half) wait_for_results();
      r = $urandom_range(99);
      if (r < 55) op = orb_pkg::OP_APPEND;
      else if (r < 80) op = orb_pkg::OP_POP;
      else if (r < 95) op = orb_pkg::OP_DUMP;
      else op = orb_pkg::OP_CLEAN;
      offer_command(op, pick_word());
    end
  endtask

  initial begin : stimulus
    rst_n          <= 1'b0;
    quiet_run      <= 1'b0;
    hold_requests  <= 0;
    in_if.valid    <= 1'b0;
    in_if.payload  <= '0;
    cfg_if.valid   <= 1'b0;
    cfg_if.payload <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // empty cases, drain to zero, clean and dump at the reset capacity
    offer_command(orb_pkg::OP_POP, pick_word());
    offer_command(orb_pkg::OP_DUMP, pick_word());
    offer_command(orb_pkg::OP_APPEND, 32'h0000_0000);
    offer_command(orb_pkg::OP_APPEND, 32'hFFFF_FFFF);
    offer_command(orb_pkg::OP_APPEND, 32'hA5A5_A5A5);
    offer_command(orb_pkg::OP_DUMP, 32'hFFFF_FFFF);
    offer_command(orb_pkg::OP_POP, 32'h0000_0000);
    offer_command(orb_pkg::OP_POP, 32'hFFFF_FFFF);
    offer_command(orb_pkg::OP_POP, pick_word());
    offer_command(orb_pkg::OP_POP, pick_word());
    offer_command(orb_pkg::OP_APPEND, 32'h5A5A_5A5A);
    offer_command(orb_pkg::OP_APPEND, 32'h0000_0001);
    offer_command(orb_pkg::OP_CLEAN, pick_word());
    offer_command(orb_pkg::OP_DUMP, pick_word());
    offer_command(orb_pkg::OP_POP, pick_word());
    offer_command(orb_pkg::OP_APPEND, 32'h8000_0000);
    offer_command(orb_pkg::OP_APPEND, 32'h7FFF_FFFF);
    offer_command(orb_pkg::OP_DUMP, pick_word());
    offer_command(orb_pkg::OP_POP, pick_word());
    offer_command(orb_pkg::OP_CLEAN, pick_word());
    wait_for_results();

    for (int i = 0; i < PLAN_LEN; i++) begin
      write_capacity(cap_plan[i]);
      if (i == 4) hold_requests <= hold_requests + 1;
      quiet_run <= (i == 6);
      run_phase(cap_plan[i]);
      wait_for_results();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && results_outstanding == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/orb_pkg.sv
design/orb_chan_if.sv
design/orb_ctrl.sv
design/orb_dp.sv
design/overwriting_ring_buffer.sv
bench/ring_buffer_checker.sv
bench/tb_overwriting_ring_buffer.sv
